[design/toi_pkg.sv]
// shared constants and types for the timestamp order index
package toi_pkg;
   localparam int MaxRows = 1024;
   localparam int PosW = $clog2(MaxRows);
   localparam int CntW = PosW + 1;
   localparam int TimeW = 64;

   typedef enum logic [1:0] {
      OP_APPEND = 2'd0,
      OP_CLEAR = 2'd1,
      OP_TRUNC = 2'd2,
      OP_READ = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0,
      ST_FULL = 2'd1,
      ST_INVALID = 2'd2
   } status_type;

   localparam logic signed [TimeW-1:0] TimeMin = {1'b1, {(TimeW-1){1'b0}}};
endpackage

[design/timestamp_order_index_core.sv]
// stable timestamp order index: top level
//
//  channel | dir | handshake       | payload
//  req     | in  | valid / stall   | op, timestamp, count_or_rank
//  rsp     | out | valid / stall   | status, row_position, row_count, in_order
//  csr     | in  | valid / ready   | capacity write data
//
// one item at a time. append walks the order store from the top, comparing
// one order entry at a time, as the order and time memories each have a
// single read port. truncate compacts the order store, then rescans kept
// timestamps. reset is synchronous; memories need no clearing. a stalled
// result holds until taken; req_stall is high while busy.
module timestamp_order_index_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [1:0]                       req_op,
   input  logic signed [toi_pkg::TimeW-1:0] req_timestamp,
   input  logic [toi_pkg::CntW-1:0]         req_count_or_rank,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [1:0]                       rsp_status,
   output logic [toi_pkg::PosW-1:0]         rsp_row_position,
   output logic [toi_pkg::CntW-1:0]         rsp_row_count,
   output logic                             rsp_in_order,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [toi_pkg::CntW-1:0]         csr_capacity
);
   localparam int PosW = toi_pkg::PosW;
   localparam int CntW = toi_pkg::CntW;
   localparam int TimeW = toi_pkg::TimeW;
   localparam logic [CntW-1:0] MaxCnt = CntW'(toi_pkg::MaxRows);

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_INS_RD, S_INS_TRD, S_INS_CMP, S_INS_PUT,
      S_TR_RD, S_TR_CHK, S_SC_RD, S_SC_CHK, S_READ_WAIT, S_DONE
   } state_type;

   // memories
   logic signed [TimeW-1:0] time_mem [toi_pkg::MaxRows];
   logic [PosW-1:0]         order_mem [toi_pkg::MaxRows];
   logic signed [TimeW-1:0] time_rd;
   logic [PosW-1:0]         order_rd;
   logic                    time_we, order_we;
   logic [PosW-1:0]         time_waddr, time_raddr, order_waddr, order_raddr;
   logic signed [TimeW-1:0] time_wdata;
   logic [PosW-1:0]         order_wdata;

   always_ff @(posedge clock) begin
      if (time_we) time_mem[time_waddr] <= time_wdata;
      time_rd <= time_mem[time_raddr];
   end

   always_ff @(posedge clock) begin
      if (order_we) order_mem[order_waddr] <= order_wdata;
      order_rd <= order_mem[order_raddr];
   end

   // control and state registers
   state_type               state_ff;
   logic [CntW-1:0]         cap_ff, rows_ff, ptr_ff, wr_ff, arg_ff;
   logic                    asc_ff, sc_asc_ff;
   logic signed [TimeW-1:0] prev_ff, ts_ff, sc_prev_ff;
   logic [1:0]              op_ff;
   logic [PosW-1:0]         hold_ff;
   logic                    rsp_valid_ff;
   logic [1:0]              rsp_status_ff;
   logic [PosW-1:0]         rsp_pos_ff;
   logic [1:0]              out_status_ff;
   logic [PosW-1:0]         out_pos_ff;
   logic [CntW-1:0]         out_count_ff;
   logic                    out_order_ff;

   logic [CntW-1:0] eff_cap;
   assign eff_cap = (cap_ff == '0 || cap_ff > MaxCnt) ? MaxCnt : cap_ff;

   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = out_status_ff;
   assign rsp_row_position = out_pos_ff;
   assign rsp_row_count = out_count_ff;
   assign rsp_in_order = out_order_ff;

   // memory port control
   always_comb begin
      time_we = 1'b0;
      time_waddr = rows_ff[PosW-1:0];
      time_wdata = ts_ff;
      time_raddr = order_rd;
      order_we = 1'b0;
      order_waddr = ptr_ff[PosW-1:0];
      order_wdata = rows_ff[PosW-1:0];
      order_raddr = ptr_ff[PosW-1:0] - PosW'(1);
      unique case (state_ff)
         S_DECODE: begin
            if (op_ff == toi_pkg::OP_READ) order_raddr = arg_ff[PosW-1:0];
         end
         S_INS_CMP: begin
            if (time_rd > ts_ff) begin
               order_we = 1'b1;
               order_wdata = hold_ff;
            end
         end
         S_INS_PUT: begin
            order_we = 1'b1;
            time_we = 1'b1;
         end
         S_TR_RD: order_raddr = ptr_ff[PosW-1:0];
         S_TR_CHK: begin
            order_we = ({1'b0, order_rd} < arg_ff);
            order_waddr = wr_ff[PosW-1:0];
            order_wdata = order_rd;
         end
         S_SC_RD: time_raddr = ptr_ff[PosW-1:0];
         default: ;
      endcase
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cap_ff <= MaxCnt;
         rows_ff <= '0;
         asc_ff <= 1'b1;
         prev_ff <= toi_pkg::TimeMin;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) cap_ff <= csr_capacity;
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  op_ff <= req_op;
                  ts_ff <= req_timestamp;
                  arg_ff <= req_count_or_rank;
                  state_ff <= S_DECODE;
               end
            end
            S_DECODE: begin
               rsp_status_ff <= toi_pkg::ST_OK;
               rsp_pos_ff <= '0;
               unique case (op_ff)
                  toi_pkg::OP_APPEND: begin
                     if (rows_ff >= eff_cap || rows_ff >= MaxCnt) begin
                        rsp_status_ff <= toi_pkg::ST_FULL;
                        state_ff <= S_DONE;
                     end else begin
                        ptr_ff <= rows_ff;
                        state_ff <= (rows_ff == '0) ? S_INS_PUT : S_INS_RD;
                     end
                  end
                  toi_pkg::OP_CLEAR: begin
                     rows_ff <= '0;
                     asc_ff <= 1'b1;
                     prev_ff <= toi_pkg::TimeMin;
                     state_ff <= S_DONE;
                  end
                  toi_pkg::OP_TRUNC: begin
                     if (arg_ff > rows_ff) begin
                        rsp_status_ff <= toi_pkg::ST_INVALID;
                        state_ff <= S_DONE;
                     end else if (arg_ff == rows_ff) begin
                        state_ff <= S_DONE;
                     end else begin
                        ptr_ff <= '0;
                        wr_ff <= '0;
                        state_ff <= S_TR_RD;
                     end
                  end
                  default: begin
                     if (arg_ff >= rows_ff) begin
                        rsp_status_ff <= toi_pkg::ST_INVALID;
                        state_ff <= S_DONE;
                     end else begin
                        state_ff <= S_READ_WAIT;
                     end
                  end
               endcase
            end
            // order entry below ptr is being fetched
            S_INS_RD: state_ff <= S_INS_TRD;
            S_INS_TRD: begin
               hold_ff <= order_rd;
               state_ff <= S_INS_CMP;
            end
            S_INS_CMP: begin
               if (time_rd > ts_ff) begin
                  ptr_ff <= ptr_ff - CntW'(1);
                  state_ff <= (ptr_ff == CntW'(1)) ? S_INS_PUT : S_INS_RD;
               end else begin
                  state_ff <= S_INS_PUT;
               end
            end
            S_INS_PUT: begin
               rsp_pos_ff <= rows_ff[PosW-1:0];
               rows_ff <= rows_ff + CntW'(1);
               if (ts_ff < prev_ff) asc_ff <= 1'b0;
               prev_ff <= ts_ff;
               state_ff <= S_DONE;
            end
            // compact order entries below target
            S_TR_RD: state_ff <= S_TR_CHK;
            S_TR_CHK: begin
               if ({1'b0, order_rd} < arg_ff) wr_ff <= wr_ff + CntW'(1);
               if (ptr_ff + CntW'(1) == rows_ff) begin
                  ptr_ff <= '0;
                  sc_asc_ff <= 1'b1;
                  sc_prev_ff <= toi_pkg::TimeMin;
                  state_ff <= (arg_ff == '0) ? S_DONE : S_SC_RD;
                  if (arg_ff == '0) begin
                     rows_ff <= '0;
                     asc_ff <= 1'b1;
                     prev_ff <= toi_pkg::TimeMin;
                  end
               end else begin
                  ptr_ff <= ptr_ff + CntW'(1);
                  state_ff <= S_TR_RD;
               end
            end
            // rescan kept timestamps for the flag
            S_SC_RD: state_ff <= S_SC_CHK;
            S_SC_CHK: begin
               if (ptr_ff + CntW'(1) == arg_ff) begin
                  rows_ff <= arg_ff;
                  asc_ff <= sc_asc_ff && !(time_rd < sc_prev_ff);
                  prev_ff <= time_rd;
                  state_ff <= S_DONE;
               end else begin
                  if (time_rd < sc_prev_ff) sc_asc_ff <= 1'b0;
                  sc_prev_ff <= time_rd;
                  ptr_ff <= ptr_ff + CntW'(1);
                  state_ff <= S_SC_RD;
               end
            end
            S_READ_WAIT: begin
               rsp_pos_ff <= order_rd;
               state_ff <= S_DONE;
            end
            // load the output register once the previous result is taken
            S_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  out_status_ff <= rsp_status_ff;
                  out_pos_ff <= rsp_pos_ff;
                  out_count_ff <= rows_ff;
                  out_order_ff <= asc_ff;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rows_ff <= MaxCnt) else $error("row count above maximum");
   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> req_stall) else $error("busy without stall");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_row_count)))
      else $error("stalled result changed");
   a_no_cfg_busy: assert property (@(posedge clock) disable iff (reset)
      csr_ready |-> (state_ff == S_IDLE)) else $error("config taken while busy");
`endif
endmodule
